// ===== src/tccs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console package
// Shared constants for the text console with cursor and scroll.
// ----------------------------------------------------------------------------
package tccs_pkg;

    localparam int DEF_TEXT_ROWS = 24;
    localparam int DEF_TEXT_COLS = 80;

    localparam int CHAR_W    = 8;
    localparam int ROW_FLD_W = 5;
    localparam int COL_FLD_W = 7;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

endpackage

// ===== src/tccs_cell_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character store
// Single-port synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module tccs_cell_mem
    import tccs_pkg::*;
#(
    parameter int DEPTH = DEF_TEXT_ROWS * DEF_TEXT_COLS,
    parameter int AW    = $clog2(DEF_TEXT_ROWS * DEF_TEXT_COLS)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [AW-1:0]     addr,
    input  logic [CHAR_W-1:0] wdata,
    output logic [CHAR_W-1:0] rdata
);

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/tccs_cursor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor and scroll control
// Keeps the cursor, the physical row at the top of the screen and a fill
// count per row, and maps logical rows to physical rows of the store.
// ----------------------------------------------------------------------------
module tccs_cursor
    import tccs_pkg::*;
#(
    parameter int TEXT_ROWS = DEF_TEXT_ROWS,
    parameter int TEXT_COLS = DEF_TEXT_COLS,
    parameter int RW        = $clog2(DEF_TEXT_ROWS),
    parameter int CW        = $clog2(DEF_TEXT_COLS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              put_en,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [RW-1:0]     rd_row,
    input  logic [CW-1:0]     rd_col,
    output logic [RW-1:0]     rd_phys,
    output logic              rd_hit,
    output logic              wr_en,
    output logic [RW-1:0]     wr_phys,
    output logic [CW-1:0]     wr_col,
    output logic [RW-1:0]     row_next,
    output logic [CW-1:0]     col_next
);

    localparam int FW = $clog2(TEXT_COLS + 1);
    localparam logic [RW-1:0] LAST_ROW = RW'(TEXT_ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(TEXT_COLS - 1);

    function automatic logic [RW-1:0] to_phys(input logic [RW-1:0] base,
                                              input logic [RW-1:0] lrow);
        logic [RW:0] sum;
        begin
            sum = {1'b0, base} + {1'b0, lrow};
            if (sum >= (RW+1)'(TEXT_ROWS))
            begin
                sum = sum - (RW+1)'(TEXT_ROWS);
            end
            return sum[RW-1:0];
        end
    endfunction

    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] base_reg;
    logic [FW-1:0] cur_fill_reg;
    logic [FW-1:0] fill_reg [TEXT_ROWS];

    logic [RW-1:0] base_next;
    logic [FW-1:0] cur_fill_next;
    logic [RW-1:0] cur_phys;
    logic [FW-1:0] fill_new;
    logic [FW-1:0] rd_fill;
    logic          is_nl;
    logic          is_cr;
    logic          is_print;
    logic          advance;
    logic          scroll;

    assign cur_phys = to_phys(base_reg, row_reg);
    assign rd_phys  = to_phys(base_reg, rd_row);

    assign is_nl    = put_en && (char_code == CH_NEWLINE);
    assign is_cr    = put_en && (char_code == CH_RETURN);
    assign is_print = put_en && !is_nl && !is_cr;
    assign advance  = is_nl || (is_print && (col_reg == LAST_COL));
    assign scroll   = advance && (row_reg == LAST_ROW);

    assign fill_new = (FW'(col_reg) + FW'(1) > cur_fill_reg) ?
                      FW'(col_reg) + FW'(1) : cur_fill_reg;

    assign rd_fill = (rd_row == row_reg) ? cur_fill_reg : fill_reg[rd_phys];
    assign rd_hit  = (FW'(rd_col) < rd_fill);

    assign wr_en   = is_print;
    assign wr_phys = cur_phys;
    assign wr_col  = col_reg;

    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        base_next     = base_reg;
        cur_fill_next = cur_fill_reg;
        if (advance)
        begin
            col_next      = '0;
            cur_fill_next = '0;
            if (scroll)
            begin
                base_next = (base_reg == LAST_ROW) ? '0 : base_reg + RW'(1);
            end
            else
            begin
                row_next = row_reg + RW'(1);
            end
        end
        else if (is_cr)
        begin
            col_next = '0;
        end
        else if (is_print)
        begin
            col_next      = col_reg + CW'(1);
            cur_fill_next = fill_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            base_reg     <= '0;
            cur_fill_reg <= '0;
            for (int i = 0; i < TEXT_ROWS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            base_reg     <= base_next;
            cur_fill_reg <= cur_fill_next;
            if (advance)
            begin
                fill_reg[cur_phys] <= is_print ? fill_new : cur_fill_reg;
            end
        end
    end

endmodule

// ===== src/text_console_cursor_scroll_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console with cursor and scroll
// A result is registered at the clock edge that accepts its item.
// Throughput is one item per cycle while out_ready does not hold the output, set by the single port of the store.
// A scroll moves the top-of-screen row pointer and copies no rows in the store.
// Reset puts the cursor at the origin and clears all row fill counts, so the
// whole screen reads as zero at once with no clearing pass.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_core
    import tccs_pkg::*;
#(
    parameter int TEXT_ROWS = DEF_TEXT_ROWS,
    parameter int TEXT_COLS = DEF_TEXT_COLS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 op,
    input  logic [CHAR_W-1:0]    char_code,
    input  logic [ROW_FLD_W-1:0] read_row,
    input  logic [COL_FLD_W-1:0] read_col,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CHAR_W-1:0]    cell_char,
    output logic [ROW_FLD_W-1:0] cursor_row_out,
    output logic [COL_FLD_W-1:0] cursor_col_out
);

    localparam int RW    = $clog2(TEXT_ROWS);
    localparam int CW    = $clog2(TEXT_COLS);
    localparam int DEPTH = TEXT_ROWS * TEXT_COLS;
    localparam int AW    = $clog2(DEPTH);

    logic                 accept;
    logic                 put_en;
    logic                 rd_in_range;
    logic [RW-1:0]        rd_phys;
    logic                 rd_hit;
    logic                 wr_en;
    logic [RW-1:0]        wr_phys;
    logic [CW-1:0]        wr_col;
    logic [RW-1:0]        row_next;
    logic [CW-1:0]        col_next;
    logic                 mem_re;
    logic [AW-1:0]        mem_addr;
    logic [CHAR_W-1:0]    mem_rdata;

    logic                 out_valid_reg;
    logic                 hit_reg;
    logic [ROW_FLD_W-1:0] row_out_reg;
    logic [COL_FLD_W-1:0] col_out_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign put_en   = accept && (op == OP_PUT);

    assign rd_in_range = (32'(read_row) < TEXT_ROWS) && (32'(read_col) < TEXT_COLS);
    assign mem_re      = accept && (op == OP_READ) && rd_in_range && rd_hit;

    assign mem_addr = wr_en ?
                      AW'(wr_phys) * AW'(TEXT_COLS) + AW'(wr_col) :
                      AW'(rd_phys) * AW'(TEXT_COLS) + AW'(CW'(read_col));

    tccs_cursor #(
        .TEXT_ROWS (TEXT_ROWS),
        .TEXT_COLS (TEXT_COLS),
        .RW        (RW),
        .CW        (CW)
    ) u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .put_en    (put_en),
        .char_code (char_code),
        .rd_row    (RW'(read_row)),
        .rd_col    (CW'(read_col)),
        .rd_phys   (rd_phys),
        .rd_hit    (rd_hit),
        .wr_en     (wr_en),
        .wr_phys   (wr_phys),
        .wr_col    (wr_col),
        .row_next  (row_next),
        .col_next  (col_next)
    );

    tccs_cell_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_cell_mem (
        .clk   (clk),
        .we    (wr_en),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (char_code),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg     <= mem_re;
            row_out_reg <= ROW_FLD_W'(row_next);
            col_out_reg <= COL_FLD_W'(col_next);
        end
    end

    assign out_valid      = out_valid_reg;
    assign cell_char      = hit_reg ? mem_rdata : '0;
    assign cursor_row_out = row_out_reg;
    assign cursor_col_out = col_out_reg;

endmodule

// ===== tb/text_console_cursor_scroll_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console with cursor and scroll testbench
// Drives put and read items through the valid/ready input channel and checks
// every result against an in-bench screen and cursor predictor. Directed
// items cover byte extremes, carriage return and reads outside the screen.
// Random text, long wrapping lines and newline-heavy text that scrolls are
// then run under three idling patterns, and a long receiver hold-off forces
// the block to stall its input.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_core_tb;

    import tccs_pkg::*;

    localparam int TEXT_ROWS    = DEF_TEXT_ROWS;
    localparam int TEXT_COLS    = DEF_TEXT_COLS;
    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 200;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [CHAR_W-1:0]    glyph;
        logic [ROW_FLD_W-1:0] row;
        logic [COL_FLD_W-1:0] col;
    } console_view_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic                 op        = OP_PUT;
    logic [CHAR_W-1:0]    char_code = '0;
    logic [ROW_FLD_W-1:0] read_row  = '0;
    logic [COL_FLD_W-1:0] read_col  = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [CHAR_W-1:0]    cell_char;
    logic [ROW_FLD_W-1:0] cursor_row_out;
    logic [COL_FLD_W-1:0] cursor_col_out;

    logic [CHAR_W-1:0] screen [TEXT_ROWS][TEXT_COLS];
    int                cur_row;
    int                cur_col;

    console_view_t expected_views [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_count     = 0;
    int cycle_count    = 0;
    int mismatch_count = 0;
    int checked_count  = 0;
    int put_count      = 0;
    int read_count     = 0;
    int scroll_count   = 0;
    int wrap_count     = 0;

    text_console_cursor_scroll_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .char_code      (char_code),
        .read_row       (read_row),
        .read_col       (read_col),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cell_char      (cell_char),
        .cursor_row_out (cursor_row_out),
        .cursor_col_out (cursor_col_out)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic void clear_screen();
        for (int r = 0; r < TEXT_ROWS; r++)
        begin
            for (int c = 0; c < TEXT_COLS; c++)
            begin
                screen[r][c] = '0;
            end
        end
        cur_row = 0;
        cur_col = 0;
    endfunction

    function automatic void advance_row();
        cur_col = 0;
        if (cur_row + 1 >= TEXT_ROWS)
        begin
            for (int r = 0; r < TEXT_ROWS - 1; r++)
            begin
                for (int c = 0; c < TEXT_COLS; c++)
                begin
                    screen[r][c] = screen[r + 1][c];
                end
            end
            for (int c = 0; c < TEXT_COLS; c++)
            begin
                screen[TEXT_ROWS - 1][c] = '0;
            end
            cur_row = TEXT_ROWS - 1;
            scroll_count++;
        end
        else
        begin
            cur_row = cur_row + 1;
        end
    endfunction

    function automatic console_view_t apply_item(input logic o, input logic [CHAR_W-1:0] ch,
                                                 input logic [ROW_FLD_W-1:0] rr,
                                                 input logic [COL_FLD_W-1:0] rc);
        console_view_t v;
        v.glyph = '0;
        if (o == OP_PUT)
        begin
            put_count++;
            if (ch == CH_NEWLINE)
            begin
                advance_row();
            end
            else if (ch == CH_RETURN)
            begin
                cur_col = 0;
            end
            else
            begin
                screen[cur_row][cur_col] = ch;
                cur_col = cur_col + 1;
                if (cur_col >= TEXT_COLS)
                begin
                    wrap_count++;
                    advance_row();
                end
            end
        end
        else
        begin
            read_count++;
            if (int'(rr) < TEXT_ROWS && int'(rc) < TEXT_COLS)
            begin
                v.glyph = screen[rr][rc];
            end
        end
        v.row = cur_row[ROW_FLD_W-1:0];
        v.col = cur_col[COL_FLD_W-1:0];
        return v;
    endfunction

    task automatic send_item(input logic o, input logic [CHAR_W-1:0] ch,
                             input logic [ROW_FLD_W-1:0] rr, input logic [COL_FLD_W-1:0] rc);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= o;
        char_code <= ch;
        read_row  <= rr;
        read_col  <= rc;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        expected_views.push_back(apply_item(o, ch, rr, rc));
    endtask

    function automatic logic [CHAR_W-1:0] rand_text_byte(input int newline_pct);
        int pick;
        pick = $urandom_range(99);
        if (pick < newline_pct)
        begin
            return CH_NEWLINE;
        end
        if (pick < newline_pct + 4)
        begin
            return CH_RETURN;
        end
        return CHAR_W'($urandom_range(255));
    endfunction

    function automatic logic [CHAR_W-1:0] rand_printable();
        logic [CHAR_W-1:0] b;
        do
        begin
            b = CHAR_W'($urandom_range(255));
        end
        while (b == CH_NEWLINE || b == CH_RETURN);
        return b;
    endfunction

    task automatic send_put(input logic [CHAR_W-1:0] ch);
        send_item(OP_PUT, ch, ROW_FLD_W'($urandom_range(31)), COL_FLD_W'($urandom_range(127)));
    endtask

    task automatic send_read(input logic [ROW_FLD_W-1:0] rr, input logic [COL_FLD_W-1:0] rc);
        send_item(OP_READ, CHAR_W'($urandom_range(255)), rr, rc);
    endtask

    task automatic send_random_read();
        logic [ROW_FLD_W-1:0] rr;
        logic [COL_FLD_W-1:0] rc;
        if ($urandom_range(99) < 90)
        begin
            rr = ROW_FLD_W'($urandom_range(TEXT_ROWS - 1));
        end
        else
        begin
            rr = ROW_FLD_W'($urandom_range(31, TEXT_ROWS));
        end
        if ($urandom_range(99) < 90)
        begin
            rc = COL_FLD_W'($urandom_range(TEXT_COLS - 1));
        end
        else
        begin
            rc = COL_FLD_W'($urandom_range(127, TEXT_COLS));
        end
        send_read(rr, rc);
    endtask

    task automatic test_put_extremes();
        send_put(8'h41);
        send_put(8'h00);
        send_put(8'hFF);
        send_put(CH_RETURN);
        send_put(8'h55);
        send_put(CH_NEWLINE);
    endtask

    task automatic test_read_cells();
        send_read(5'd0, 7'd0);
        send_read(5'd0, 7'd1);
        send_read(5'd0, 7'd2);
        send_read(5'd0, 7'd3);
        send_read(5'(TEXT_ROWS - 1), 7'(TEXT_COLS - 1));
        send_read(5'(TEXT_ROWS), 7'd0);
        send_read(5'd31, 7'd127);
        send_read(5'd0, 7'(TEXT_COLS));
        send_read(5'd5, 7'd127);
    endtask

    task automatic test_scroll_text(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 25)
            begin
                send_random_read();
            end
            else
            begin
                send_put(rand_text_byte(25));
            end
        end
    endtask

    task automatic test_line_wrap(input int lines);
        int len;
        for (int l = 0; l < lines; l++)
        begin
            len = TEXT_COLS + $urandom_range(20);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(99) < 10)
                begin
                    send_random_read();
                end
                send_put(rand_printable());
            end
        end
    endtask

    task automatic test_random_mix(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 30)
            begin
                send_random_read();
            end
            else
            begin
                send_put(rand_text_byte(8));
            end
        end
    endtask

    task automatic test_receiver_hold(input int n);
        hold_requests <= hold_requests + 1;
        test_random_mix(n);
    endtask

    task automatic report_mismatch(input string what, input console_view_t want);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
        begin
            $display("%s at result %0d: expected cell %h row %0d col %0d,",
                     what, checked_count, want.glyph, want.row, want.col);
            $display("    got cell %h row %0d col %0d",
                     cell_char, cursor_row_out, cursor_col_out);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        console_view_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_views.size() == 0)
                begin
                    want = '0;
                    report_mismatch("Unexpected result", want);
                end
                else
                begin
                    want = expected_views.pop_front();
                    if (cell_char !== want.glyph || cursor_row_out !== want.row
                        || cursor_col_out !== want.col)
                    begin
                        report_mismatch("Wrong result", want);
                    end
                end
                checked_count++;
            end
            if (holds_served != hold_requests)
            begin
                holds_served = holds_served + 1;
                hold_count   = LONG_HOLD;
            end
            if (hold_count > 0)
            begin
                hold_count = hold_count - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_views.size());
            $display("text_console_cursor_scroll_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        clear_screen();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 25;
        recv_stall_pct = 72;
        test_put_extremes();
        test_read_cells();

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 25;
                    recv_stall_pct = 72;
                end
                1:
                begin
                    send_idle_pct  = 72;
                    recv_stall_pct = 25;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            test_scroll_text(140);
            test_line_wrap(2);
            test_random_mix(80);
        end
        test_receiver_hold(60);

        in_valid <= 1'b0;
        while (expected_views.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results from %0d puts and %0d reads in %0d cycles.",
                 checked_count, put_count, read_count, cycle_count);
        $display("The screen scrolled %0d times and %0d lines wrapped at the right edge.",
                 scroll_count, wrap_count);
        if (mismatch_count == 0)
        begin
            $display("text_console_cursor_scroll_core: match");
        end
        else
        begin
            $display("%0d results differed.", mismatch_count);
            $display("text_console_cursor_scroll_core: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tccs_pkg.sv
src/tccs_cell_mem.sv
src/tccs_cursor.sv
src/text_console_cursor_scroll_core.sv
tb/text_console_cursor_scroll_core_tb.sv
